### rtl/aclip_pkg.sv
// Shared types and constants of the arctangent soft-clip overdrive.
// Holds the CORDIC angle table, datapath widths and register indexes.
// No dependencies.
package aclip_pkg;

  // CORDIC vector width: Q1.31 sample times a 10-bit gain plus gain growth
  localparam int CordicW = 45;
  // angle accumulator, (2/pi)*angle in Q2.30
  localparam int AngleW  = 32;
  // sample widened to Q1.31
  localparam int WideW   = 32;
  // level squares, products and the scaled sum
  localparam int SqW     = 16;
  localparam int ProdW   = 49;
  localparam int SumW    = 51;
  // volume scale of the sum and quotient headroom of the divider
  localparam int Divisor = 10000;
  localparam int DivHead = 14;

  // configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 10;
  localparam int GainW    = 10;
  localparam int LevelW   = 8;

  localparam logic [CfgIdxW-1:0] REG_DRIVE_GAIN  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_DRIVE_LEVEL = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_CLEAN_LEVEL = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_BYPASS      = CfgIdxW'(3);

  localparam logic [GainW-1:0]  GAIN_RST  = GainW'(0);
  localparam logic [LevelW-1:0] DRIVE_RST = LevelW'(0);
  localparam logic [LevelW-1:0] CLEAN_RST = LevelW'(100);

  // round((2/pi)*atan(2^-i)*2^30)
  localparam int MaxSteps = 24;
  localparam logic [AngleW-1:0] ATAN_TAB [MaxSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef logic signed [CordicW-1:0] cordic_t;
  typedef logic signed [AngleW-1:0]  angle_t;

  // control that travels with every word down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic bypass;
  } ctl_t;

endpackage

### rtl/aclip_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its pipeline register.
// Depends on aclip_pkg (widths, angle table, control struct).
module aclip_cordic_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int STEP        = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aclip_pkg::ctl_t               ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  aclip_pkg::cordic_t            x_i,
  input  aclip_pkg::cordic_t            y_i,
  input  aclip_pkg::angle_t             z_i,
  output aclip_pkg::ctl_t               ctl_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output aclip_pkg::cordic_t            x_o,
  output aclip_pkg::cordic_t            y_o,
  output aclip_pkg::angle_t             z_o
);

  localparam aclip_pkg::angle_t Tab = aclip_pkg::angle_t'(aclip_pkg::ATAN_TAB[STEP]);

  aclip_pkg::ctl_t    ctl_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  aclip_pkg::cordic_t x_d, x_q, y_d, y_q, dx, dy;
  aclip_pkg::angle_t  z_d, z_q;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  // rotate toward the x axis
  always_comb begin
    if (!y_i[aclip_pkg::CordicW-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + Tab;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Tab;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_i;
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
  end

  assign ctl_o    = ctl_q;
  assign sample_o = sample_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign z_o      = z_q;

endmodule

### rtl/aclip_scale.sv
// Volume scaling, rounding and range check ahead of the divide stage.
// Four register stages: products, sum, magnitude, rounded shift and clip test.
// Depends on aclip_pkg.
module aclip_scale #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  aclip_pkg::ctl_t                       ctl_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  aclip_pkg::angle_t                     angle_i,
  input  logic [aclip_pkg::LevelW-1:0]          drive_level_i,
  input  logic [aclip_pkg::LevelW-1:0]          clean_level_i,
  output aclip_pkg::ctl_t                       ctl_o,
  output logic signed [SAMPLE_BITS-1:0]         sample_o,
  output logic                                  neg_o,
  output logic                                  clip_o,
  output logic [SAMPLE_BITS+aclip_pkg::DivHead-1:0] rem_o
);

  localparam int Shift = aclip_pkg::WideW - SAMPLE_BITS;
  localparam int DivW  = SAMPLE_BITS + aclip_pkg::DivHead;
  localparam int SumW  = aclip_pkg::SumW;
  localparam int ProdW = aclip_pkg::ProdW;
  localparam logic [SumW-1:0] Half   = SumW'(aclip_pkg::Divisor / 2) << Shift;
  localparam logic [SumW-1:0] LimPos = SumW'(aclip_pkg::Divisor) << (SAMPLE_BITS - 1);
  localparam logic [SumW-1:0] LimNeg =
    LimPos + SumW'(aclip_pkg::Divisor);

  // level squares are registered from the configured levels
  logic [aclip_pkg::SqW-1:0] drive_sq_q, clean_sq_q;

  aclip_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic signed [SAMPLE_BITS-1:0] smp1_q, smp2_q, smp3_q, smp4_q;
  logic signed [aclip_pkg::WideW-1:0] xs;
  logic signed [ProdW-1:0] pdrv_d, pdrv_q, pcln_d, pcln_q;
  logic signed [SumW-1:0]  sum_d, sum_q;
  logic [SumW-1:0] mag_d, mag_q, rnd;
  logic neg3_q, neg4_q, clip_d, clip4_q;
  logic [DivW-1:0] rem4_q;

  assign xs = aclip_pkg::WideW'(sample_i) <<< Shift;

  assign pdrv_d = ProdW'(angle_i) * ProdW'($signed({1'b0, drive_sq_q}));
  assign pcln_d = ProdW'(xs) * ProdW'($signed({1'b0, clean_sq_q}));
  assign sum_d  = (SumW'(pdrv_q) <<< 1) + SumW'(pcln_q);
  assign mag_d  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign rnd    = (mag_q + Half) >> Shift;
  assign clip_d = neg3_q ? (rnd >= LimNeg) : (rnd >= LimPos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    drive_sq_q <= drive_level_i * drive_level_i;
    clean_sq_q <= clean_level_i * clean_level_i;
    smp1_q     <= sample_i;
    pdrv_q     <= pdrv_d;
    pcln_q     <= pcln_d;
    smp2_q     <= smp1_q;
    sum_q      <= sum_d;
    smp3_q     <= smp2_q;
    mag_q      <= mag_d;
    neg3_q     <= sum_q[SumW-1];
    smp4_q     <= smp3_q;
    neg4_q     <= neg3_q;
    clip4_q    <= clip_d;
    rem4_q     <= rnd[DivW-1:0];
  end

  assign ctl_o    = ctl4_q;
  assign sample_o = smp4_q;
  assign neg_o    = neg4_q;
  assign clip_o   = clip4_q;
  assign rem_o    = rem4_q;

endmodule

### rtl/aclip_div_cell.sv
// Divide by the volume scale: multiply by its reciprocal and keep the quotient bits.
// Depends on aclip_pkg.
module aclip_div_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  aclip_pkg::ctl_t                           ctl_i,
  input  logic signed [SAMPLE_BITS-1:0]             sample_i,
  input  logic                                      neg_i,
  input  logic                                      clip_i,
  input  logic [SAMPLE_BITS+aclip_pkg::DivHead-1:0] rem_i,
  output aclip_pkg::ctl_t                           ctl_o,
  output logic signed [SAMPLE_BITS-1:0]             sample_o,
  output logic                                      neg_o,
  output logic                                      clip_o,
  output logic [SAMPLE_BITS-1:0]                    quo_o
);

  localparam int DivW  = SAMPLE_BITS + aclip_pkg::DivHead;
  // reciprocal rounded up with enough shift that the quotient is exact for
  // every DivW-bit dividend (the rounding error of the divisor is below 2^DivHead)
  localparam int RecSh = DivW + aclip_pkg::DivHead;
  // the divisor exceeds 2^13, so the reciprocal fits in RecSh - 13 bits
  localparam int RecW  = RecSh - 13;
  localparam int MulW  = DivW + RecW;
  localparam logic [63:0] RecipFull =
    ((64'd1 << RecSh) + 64'(aclip_pkg::Divisor) - 64'd1) / 64'(aclip_pkg::Divisor);
  localparam logic [RecW-1:0] Recip = RecipFull[RecW-1:0];

  aclip_pkg::ctl_t ctl_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic neg_q, clip_q;
  logic [MulW-1:0] prod;
  logic [SAMPLE_BITS-1:0] quo_q;

  assign prod = {{RecW{1'b0}}, rem_i} * {{DivW{1'b0}}, Recip};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_i;
    neg_q    <= neg_i;
    clip_q   <= clip_i;
    quo_q    <= prod[RecSh +: SAMPLE_BITS];
  end

  assign ctl_o    = ctl_q;
  assign sample_o = sample_q;
  assign neg_o    = neg_q;
  assign clip_o   = clip_q;
  assign quo_o    = quo_q;

endmodule

### rtl/atan_soft_clip_overdrive.sv
// Top level of the arctangent soft-clip overdrive.
// Depends on aclip_pkg, aclip_cordic_cell, aclip_scale and aclip_div_cell.
//
// Takes one sample per clock and returns one result per sample, in order,
// once the start word has passed through, in turn, one entry stage
// (sample times drive gain), one CORDIC cell per step, four scaling stages,
// one divide stage (multiply by the reciprocal of the volume scale), and the
// output register. Every stage advances every cycle, so busy never rises and
// a new start word may follow in the next cycle. There is no backpressure:
// out_valid_o is high for exactly one cycle per sample and the result is
// gone after it, so the receiver must take it then. Write the registers
// only while no sample is in flight; cfg_ready_o is always high and writes
// to indexes past the bypass register are dropped.
module atan_soft_clip_overdrive #(
  parameter int SAMPLE_BITS  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // sample channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample_i,
  input  logic                                  in_last_i,
  // result channel
  output logic                                  out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]         out_sample_o,
  output logic                                  clipped_o,
  output logic                                  out_last_o,
  // register write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [aclip_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [aclip_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int Shift = aclip_pkg::WideW - SAMPLE_BITS;
  localparam int DivW  = SAMPLE_BITS + aclip_pkg::DivHead;
  localparam logic [SAMPLE_BITS-1:0] MaxPos = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] MaxNeg = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [aclip_pkg::GainW-1:0]  drive_gain_q;
  logic [aclip_pkg::LevelW-1:0] drive_level_q, clean_level_q;
  logic                         bypass_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_gain_q  <= aclip_pkg::GAIN_RST;
      drive_level_q <= aclip_pkg::DRIVE_RST;
      clean_level_q <= aclip_pkg::CLEAN_RST;
      bypass_q      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        aclip_pkg::REG_DRIVE_GAIN:  drive_gain_q  <= cfg_data_i[aclip_pkg::GainW-1:0];
        aclip_pkg::REG_DRIVE_LEVEL: drive_level_q <= cfg_data_i[aclip_pkg::LevelW-1:0];
        aclip_pkg::REG_CLEAN_LEVEL: clean_level_q <= cfg_data_i[aclip_pkg::LevelW-1:0];
        aclip_pkg::REG_BYPASS:      bypass_q      <= cfg_data_i[0];
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Entry stage: widen the sample to Q1.31 and form the CORDIC start vector
  // (1.0, x * gain). Bypass is latched with the word so it rides along.
  // ---------------------------------------------------------------------
  assign busy = 1'b0;

  aclip_pkg::ctl_t ctl_in, ctl_c [CORDIC_STEPS+1];
  logic signed [SAMPLE_BITS-1:0] smp_c [CORDIC_STEPS+1];
  aclip_pkg::cordic_t x_c [CORDIC_STEPS+1];
  aclip_pkg::cordic_t y_c [CORDIC_STEPS+1];
  aclip_pkg::angle_t  z_c [CORDIC_STEPS+1];

  aclip_pkg::ctl_t    ctl0_q;
  logic signed [SAMPLE_BITS-1:0] smp0_q;
  logic signed [aclip_pkg::WideW-1:0] xs_in;
  aclip_pkg::cordic_t y0_d, y0_q;

  assign ctl_in = '{valid: start && !busy, last: in_last_i, bypass: bypass_q};
  assign xs_in  = aclip_pkg::WideW'(in_sample_i) <<< Shift;
  assign y0_d   = aclip_pkg::cordic_t'(xs_in) *
                  aclip_pkg::cordic_t'($signed({1'b0, drive_gain_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q <= ctl_in;
    end
  end

  always_ff @(posedge clk_i) begin
    smp0_q <= in_sample_i;
    y0_q   <= y0_d;
  end

  assign ctl_c[0] = ctl0_q;
  assign smp_c[0] = smp0_q;
  assign x_c[0]   = aclip_pkg::cordic_t'(1) <<< (aclip_pkg::WideW - 1);
  assign y_c[0]   = y0_q;
  assign z_c[0]   = '0;

  // ---------------------------------------------------------------------
  // CORDIC chain: one cell per micro-rotation, each hands its vector on
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    aclip_cordic_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .STEP        (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl_c[i]),
      .sample_i (smp_c[i]),
      .x_i      (x_c[i]),
      .y_i      (y_c[i]),
      .z_i      (z_c[i]),
      .ctl_o    (ctl_c[i+1]),
      .sample_o (smp_c[i+1]),
      .x_o      (x_c[i+1]),
      .y_o      (y_c[i+1]),
      .z_o      (z_c[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Scale by the volumes, round, and test for overflow
  // ---------------------------------------------------------------------
  aclip_pkg::ctl_t ctl_s, ctl_e;
  logic signed [SAMPLE_BITS-1:0] smp_s, smp_e;
  logic neg_s, clip_s, neg_e, clip_e;
  logic [DivW-1:0] rem_s;
  logic [SAMPLE_BITS-1:0] quo_e;

  aclip_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl_c[CORDIC_STEPS]),
    .sample_i      (smp_c[CORDIC_STEPS]),
    .angle_i       (z_c[CORDIC_STEPS]),
    .drive_level_i (drive_level_q),
    .clean_level_i (clean_level_q),
    .ctl_o         (ctl_s),
    .sample_o      (smp_s),
    .neg_o         (neg_s),
    .clip_o        (clip_s),
    .rem_o         (rem_s)
  );

  // ---------------------------------------------------------------------
  // Divide stage: multiply the rounded magnitude by the reciprocal of the
  // volume scale and keep the quotient bits
  // ---------------------------------------------------------------------
  aclip_div_cell #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_s),
    .sample_i (smp_s),
    .neg_i    (neg_s),
    .clip_i   (clip_s),
    .rem_i    (rem_s),
    .ctl_o    (ctl_e),
    .sample_o (smp_e),
    .neg_o    (neg_e),
    .clip_o   (clip_e),
    .quo_o    (quo_e)
  );

  // ---------------------------------------------------------------------
  // Output register: apply sign, saturate, or pass the dry sample in bypass
  // ---------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] res_d;
  logic clip_out_d;
  logic out_valid_q, out_last_q, clipped_q;
  logic [SAMPLE_BITS-1:0] out_sample_q;

  always_comb begin
    if (ctl_e.bypass) begin
      res_d      = smp_e;
      clip_out_d = 1'b0;
    end else if (clip_e) begin
      res_d      = neg_e ? MaxNeg : MaxPos;
      clip_out_d = 1'b1;
    end else begin
      res_d      = neg_e ? SAMPLE_BITS'(-quo_e) : quo_e;
      clip_out_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= ctl_e.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sample_q <= res_d;
    clipped_q    <= clip_out_d;
    out_last_q   <= ctl_e.last;
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign clipped_o    = clipped_q;
  assign out_last_o   = out_last_q;

endmodule

### rtl/aclip_checker.sv
// Port-level checks of the arctangent soft-clip overdrive, bound to the top.
// Depends on the top level's ports only.
module aclip_checker #(
  parameter int SAMPLE_BITS  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid_o,
  input logic signed [SAMPLE_BITS-1:0] out_sample_o,
  input logic                          clipped_o
);

  localparam int Lat = CORDIC_STEPS + 7;
  localparam logic [SAMPLE_BITS-1:0] MaxPos = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] MaxNeg = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic take;
  assign take = start && !busy;

  // every accepted word comes out after the fixed latency
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##Lat out_valid_o)
    else $error("accepted word did not come out after the pipeline latency");

  // no result without a word accepted the latency before
  a_lat_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(take, Lat))
    else $error("result strobe without a matching accepted word");

  // a clipped result sits at one of the range limits
  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (out_sample_o == MaxPos || out_sample_o == MaxNeg))
    else $error("clip flag set on a sample inside the range");

endmodule

bind atan_soft_clip_overdrive aclip_checker #(
  .SAMPLE_BITS  (SAMPLE_BITS),
  .CORDIC_STEPS (CORDIC_STEPS)
) u_aclip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .out_valid_o  (out_valid_o),
  .out_sample_o (out_sample_o),
  .clipped_o    (clipped_o)
);
